// ----- rtl/http_chunked_body_decoder_top_macros.svh -----
// Assertion macros used by the chunked body decoder top.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/chd_pkg.sv -----
// Package for the chunked body decoder: widths, codes, phase and result types.
// Used by chd_cfg, chd_core and http_chunked_body_decoder_top.
package chd_pkg;

    localparam int SIZE_LINE_MAX_DEF = 8;
    localparam int BYTE_W            = 8;
    localparam int SIZE_W            = 24;
    localparam int TOTAL_W           = 32;
    localparam int HEX_W             = 4;
    localparam int ADDR_W            = 3;
    localparam int REG_IDX_W         = ADDR_W - 2;
    localparam int DATA_W            = 32;

    localparam logic [SIZE_W-1:0]    SIZE_SAT       = '1;
    localparam logic [TOTAL_W-1:0]   BODY_LIMIT_RST = '1;
    localparam logic [BYTE_W-1:0]    CHAR_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0]    CHAR_LF        = 8'h0A;
    localparam logic [REG_IDX_W-1:0] REG_BODY_LIMIT = '0;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_CRLF,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PAYLOAD,
        KIND_FINISHED,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   out_byte;
        logic [TOTAL_W-1:0]  body_length;
    } result_t;

endpackage

// ----- rtl/http_chunked_body_decoder_top.sv -----
// HTTP chunked body decoder: one received body byte in, one result out per
// transfer. A byte is taken into an input register; the framing logic turns
// it into a result in a single pass and the result is held in an output
// register until the downstream side takes it. The block sustains one byte
// per clock cycle while the downstream side keeps taking results. A result
// passes through the input register and then the output register before it
// can be taken. While a result waits, the block accepts one more byte into its
// input register, since the input and output registers form a two-deep
// pipeline. Each input byte yields exactly one result: kind
// none, payload byte, body finished (with the total length) or error. A byte
// with tlast set ends the stream: the result is an error unless the body has
// finished or failed by that byte, and the decoder then starts over for a new
// body. The body length limit is written over the APB-style port at byte
// address 0; write it only while no transfer is in flight. Size lines longer
// than SIZE_LINE_MAX - 1 bytes are rejected.
// Depends on chd_pkg, chd_cfg, chd_core and the assertion macro header.
`include "http_chunked_body_decoder_top_macros.svh"

module http_chunked_body_decoder_top
    import chd_pkg::*;
#(
    parameter int SIZE_LINE_MAX = SIZE_LINE_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input byte stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // end_of_input
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // [7:0] out_byte, [39:8] body_length
    output logic [1:0]         m_tuser,   // [1:0] kind
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg,  in_byte_next;
    logic               in_last_reg,  in_last_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_result_reg, out_result_next;

    logic               in_xfer;
    logic               advance;
    logic [TOTAL_W-1:0] body_limit;
    result_t            step_result;

    chd_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .body_limit (body_limit)
    );

    chd_core #(
        .SIZE_LINE_MAX (SIZE_LINE_MAX)
    ) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (in_byte_reg),
        .end_of_input (in_last_reg),
        .body_limit   (body_limit),
        .result       (step_result)
    );

    // Advance the held byte when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        in_last_next    = in_last_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next  = 1'b1;
            out_result_next = step_result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_byte_reg    <= in_byte_next;
        in_last_reg    <= in_last_next;
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.kind;
    assign m_tdata  = {out_result_reg.body_length, out_result_reg.out_byte};

    `CHD_ASSERT_NXT(a_in_held, in_xfer, in_valid_reg, "accepted byte not held in input register")
    `CHD_ASSERT_NXT(a_result_loaded, advance, m_tvalid, "advanced byte produced no result")
    `CHD_ASSERT_IMP(a_payload_counted, m_tvalid && (m_tuser == KIND_PAYLOAD),
                    m_tdata[39:8] != '0, "payload result with zero body length")
    `CHD_ASSERT_IMP(a_byte_zero, m_tvalid && (m_tuser != KIND_PAYLOAD),
                    m_tdata[7:0] == '0, "non-payload result carries a byte")

endmodule

// ----- rtl/chd_cfg.sv -----
// APB-style register file holding the body length limit.
// Depends on chd_pkg.
module chd_cfg
    import chd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [TOTAL_W-1:0] body_limit
);

    logic [TOTAL_W-1:0]   body_limit_reg;
    logic [TOTAL_W-1:0]   body_limit_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_BODY_LIMIT);

    always_comb
    begin
        body_limit_next = body_limit_reg;
        if (wr_en)
        begin
            body_limit_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_limit_reg <= BODY_LIMIT_RST;
        end
        else
        begin
            body_limit_reg <= body_limit_next;
        end
    end

    assign prdata     = (reg_idx == REG_BODY_LIMIT) ? body_limit_reg : '0;
    assign body_limit = body_limit_reg;

endmodule

// ----- rtl/chd_core.sv -----
// Framing state machine of the chunked body decoder and its per-byte result.
// Depends on chd_pkg.
module chd_core
    import chd_pkg::*;
#(
    parameter int SIZE_LINE_MAX = SIZE_LINE_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               end_of_input,
    input  logic [TOTAL_W-1:0] body_limit,
    output result_t            result
);

    localparam int CNT_W = $clog2(SIZE_LINE_MAX + 1);

    phase_t              phase_reg,     phase_next,     phase_step;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [SIZE_W-1:0]   size_reg,      size_next;
    logic                closed_reg,    closed_next;
    logic                seen_reg,      seen_next;
    logic [SIZE_W-1:0]   remaining_reg, remaining_next;
    logic                crlf_reg,      crlf_next;
    logic [TOTAL_W-1:0]  total_reg,     total_next,     total_step;

    logic [CNT_W-1:0]    count_inc;
    logic                line_full;
    logic                is_cr;
    logic                is_lf;
    logic                hex_ok;
    logic [HEX_W-1:0]    hex_val;
    logic [SIZE_W-1:0]   size_acc;
    logic                at_limit;
    logic [SIZE_W-1:0]   rem_dec;
    kind_t               kind_step;

    // Shared decode of the current byte
    always_comb
    begin
        count_inc = count_reg + CNT_W'(1);
        line_full = (count_inc >= CNT_W'(SIZE_LINE_MAX));
        is_cr     = (data_byte == CHAR_CR);
        is_lf     = (data_byte == CHAR_LF);
        hex_ok    = 1'b0;
        hex_val   = '0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            hex_ok  = 1'b1;
            hex_val = HEX_W'(data_byte - 8'h30);
        end
        else if (data_byte >= 8'h61 && data_byte <= 8'h66)
        begin
            hex_ok  = 1'b1;
            hex_val = HEX_W'(data_byte - 8'h57);
        end
        else if (data_byte >= 8'h41 && data_byte <= 8'h46)
        begin
            hex_ok  = 1'b1;
            hex_val = HEX_W'(data_byte - 8'h37);
        end
        // shift in one digit, saturating once the top nibble would overflow
        size_acc = (size_reg[SIZE_W-1 -: HEX_W] != '0) ? SIZE_SAT
                                                       : {size_reg[SIZE_W-HEX_W-1:0], hex_val};
        at_limit   = (total_reg >= body_limit);
        rem_dec    = (remaining_reg != '0) ? remaining_reg - SIZE_W'(1) : '0;
        total_step = (phase_reg == PH_DATA && !at_limit) ? total_reg + TOTAL_W'(1) : total_reg;
    end

    // Next state
    always_comb
    begin
        phase_step     = phase_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        closed_next    = closed_reg;
        seen_next      = seen_reg;
        remaining_next = remaining_reg;
        crlf_next      = crlf_reg;
        total_next     = total_step;
        unique case (phase_reg)
            PH_SIZE:
            begin
                count_next = count_inc;
                if (line_full)
                begin
                    phase_step = PH_DONE;
                end
                else if (is_lf)
                begin
                    if (size_reg == '0)
                    begin
                        phase_step = PH_DONE;
                    end
                    else
                    begin
                        remaining_next = size_reg;
                        phase_step     = PH_DATA;
                        count_next     = '0;
                        size_next      = '0;
                        closed_next    = 1'b0;
                        seen_next      = 1'b0;
                    end
                end
                else if (hex_ok)
                begin
                    if (!closed_reg)
                    begin
                        size_next = size_acc;
                        seen_next = 1'b1;
                    end
                end
                else if (is_cr)
                begin
                    if (seen_reg)
                    begin
                        closed_next = 1'b1;
                    end
                end
                else
                begin
                    phase_step = PH_DONE;
                end
            end
            PH_DATA:
            begin
                if (at_limit)
                begin
                    phase_step = PH_DONE;
                end
                else
                begin
                    remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_step = PH_CRLF;
                        crlf_next  = 1'b0;
                    end
                end
            end
            PH_CRLF:
            begin
                if (!crlf_reg)
                begin
                    if (is_cr)
                    begin
                        crlf_next = 1'b1;
                    end
                    else
                    begin
                        phase_step = PH_DONE;
                    end
                end
                else if (is_lf)
                begin
                    crlf_next   = 1'b0;
                    phase_step  = PH_SIZE;
                    count_next  = '0;
                    size_next   = '0;
                    closed_next = 1'b0;
                    seen_next   = 1'b0;
                end
                else
                begin
                    phase_step = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_step = PH_DONE;
            end
            default:
            begin
                phase_step = PH_DONE;
            end
        endcase

        phase_next = phase_step;
        // end of input returns everything to its reset value
        if (end_of_input)
        begin
            phase_next     = PH_SIZE;
            count_next     = '0;
            size_next      = '0;
            closed_next    = 1'b0;
            seen_next      = 1'b0;
            remaining_next = '0;
            crlf_next      = 1'b0;
            total_next     = '0;
        end
    end

    // Outputs
    always_comb
    begin
        kind_step = KIND_NONE;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (line_full)
                begin
                    kind_step = KIND_ERROR;
                end
                else if (is_lf)
                begin
                    kind_step = (size_reg == '0) ? KIND_FINISHED : KIND_NONE;
                end
                else if (!hex_ok && !is_cr)
                begin
                    kind_step = KIND_ERROR;
                end
            end
            PH_DATA:
            begin
                kind_step = at_limit ? KIND_ERROR : KIND_PAYLOAD;
            end
            PH_CRLF:
            begin
                if (crlf_reg ? !is_lf : !is_cr)
                begin
                    kind_step = KIND_ERROR;
                end
            end
            PH_DONE:
            begin
                kind_step = KIND_NONE;
            end
            default:
            begin
                kind_step = KIND_NONE;
            end
        endcase

        result.kind        = kind_step;
        result.out_byte    = (kind_step == KIND_PAYLOAD) ? data_byte : '0;
        result.body_length = total_step;
        if (end_of_input && phase_step != PH_DONE)
        begin
            result.kind     = KIND_ERROR;
            result.out_byte = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            count_reg     <= '0;
            size_reg      <= '0;
            closed_reg    <= 1'b0;
            seen_reg      <= 1'b0;
            remaining_reg <= '0;
            crlf_reg      <= 1'b0;
            total_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            size_reg      <= size_next;
            closed_reg    <= closed_next;
            seen_reg      <= seen_next;
            remaining_reg <= remaining_next;
            crlf_reg      <= crlf_next;
            total_reg     <= total_next;
        end
    end

endmodule

// ----- tb/sv/chd_decode_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the chunked body decoder: follows byte, result and register
// transfers, predicts every result and compares the result stream field by field.
// Depends on chd_pkg.

module chd_decode_checker
    import chd_pkg::*;
#(
    parameter int SIZE_LINE_MAX = SIZE_LINE_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [39:0]        m_tdata,
    input  logic [1:0]         m_tuser,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic [DATA_W-1:0]  prdata,
    input  logic               pready,
    output int                 mismatch_count,
    output int                 awaited
);

    localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_BODY_LIMIT, 2'b00};

    // predicted decoder state
    logic [TOTAL_W-1:0] limit_reg     = BODY_LIMIT_RST;
    phase_t             dec_phase     = PH_SIZE;
    int unsigned        line_count    = 0;
    logic [SIZE_W-1:0]  size_acc      = '0;
    logic               digits_closed = 1'b0;
    logic               digit_seen    = 1'b0;
    logic [SIZE_W-1:0]  chunk_left    = '0;
    logic               cr_seen       = 1'b0;
    logic [TOTAL_W-1:0] payload_total = '0;

    result_t pending_results[$];

    function automatic void clear_line();
        line_count    = 0;
        size_acc      = '0;
        digits_closed = 1'b0;
        digit_seen    = 1'b0;
    endfunction

    function automatic void clear_decoder();
        dec_phase     = PH_SIZE;
        clear_line();
        chunk_left    = '0;
        cr_seen       = 1'b0;
        payload_total = '0;
    endfunction

    function automatic logic hex_nibble(input logic [BYTE_W-1:0] b,
                                        output logic [HEX_W-1:0] nib);
        nib = '0;
        if (b >= 8'h30 && b <= 8'h39) nib = HEX_W'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) nib = HEX_W'(b - 8'h61 + 8'd10);
        else if (b >= 8'h41 && b <= 8'h46) nib = HEX_W'(b - 8'h41 + 8'd10);
        else return 1'b0;
        return 1'b1;
    endfunction

    // Advance the predicted decoder by one byte and return the result it gives.
    function automatic result_t decode_step(input logic [BYTE_W-1:0] b, input logic eoi);
        result_t                 r;
        logic [HEX_W-1:0]        nib;
        logic                    is_hex;
        logic [SIZE_W+HEX_W-1:0] grown;
        r.kind     = KIND_NONE;
        r.out_byte = '0;
        is_hex     = hex_nibble(b, nib);
        case (dec_phase)
            PH_SIZE:
            begin
                line_count++;
                if (line_count >= SIZE_LINE_MAX)
                begin
                    r.kind    = KIND_ERROR;
                    dec_phase = PH_DONE;
                end
                else if (b == CHAR_LF)
                begin
                    if (size_acc == '0)
                    begin
                        r.kind    = KIND_FINISHED;
                        dec_phase = PH_DONE;
                    end
                    else
                    begin
                        chunk_left = size_acc;
                        dec_phase  = PH_DATA;
                        clear_line();
                    end
                end
                else if (is_hex)
                begin
                    if (!digits_closed)
                    begin
                        grown      = {size_acc, nib};
                        size_acc   = (grown > SIZE_SAT) ? SIZE_SAT : grown[SIZE_W-1:0];
                        digit_seen = 1'b1;
                    end
                end
                else if (b == CHAR_CR)
                begin
                    if (digit_seen) digits_closed = 1'b1;
                end
                else
                begin
                    r.kind    = KIND_ERROR;
                    dec_phase = PH_DONE;
                end
            end
            PH_DATA:
            begin
                if (payload_total >= limit_reg)
                begin
                    r.kind    = KIND_ERROR;
                    dec_phase = PH_DONE;
                end
                else
                begin
                    r.kind     = KIND_PAYLOAD;
                    r.out_byte = b;
                    payload_total++;
                    if (chunk_left != '0) chunk_left--;
                    if (chunk_left == '0)
                    begin
                        dec_phase = PH_CRLF;
                        cr_seen   = 1'b0;
                    end
                end
            end
            PH_CRLF:
            begin
                if (!cr_seen)
                begin
                    if (b == CHAR_CR)
                    begin
                        cr_seen = 1'b1;
                    end
                    else
                    begin
                        r.kind    = KIND_ERROR;
                        dec_phase = PH_DONE;
                    end
                end
                else if (b == CHAR_LF)
                begin
                    cr_seen   = 1'b0;
                    dec_phase = PH_SIZE;
                    clear_line();
                end
                else
                begin
                    r.kind    = KIND_ERROR;
                    dec_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        // a stream that stops before the body has finished or failed is an error
        if (eoi && dec_phase != PH_DONE)
        begin
            r.kind     = KIND_ERROR;
            r.out_byte = '0;
        end
        r.body_length = payload_total;
        if (eoi) clear_decoder();
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result transfer with no byte waiting for it");
        end
        else
        begin
            want = pending_results.pop_front();
            if (m_tuser !== want.kind)
                report_mismatch($sformatf("kind %0d, predicted %0d", m_tuser, want.kind));
            if (m_tdata[BYTE_W-1:0] !== want.out_byte)
                report_mismatch($sformatf("out_byte 0x%02h, predicted 0x%02h",
                                          m_tdata[BYTE_W-1:0], want.out_byte));
            if (m_tdata[BYTE_W +: TOTAL_W] !== want.body_length)
                report_mismatch($sformatf("body_length %0d, predicted %0d",
                                          m_tdata[BYTE_W +: TOTAL_W], want.body_length));
        end
    endtask

    // All channels are sampled as they stood before the edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg = BODY_LIMIT_RST;
            clear_decoder();
            pending_results.delete();
            awaited = 0;
        end
        else
        begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready)
                pending_results.push_back(decode_step(s_tdata, s_tlast));
            if (psel && penable && pready && paddr == LIMIT_ADDR)
            begin
                if (pwrite)
                    limit_reg = pwdata;
                else if (prdata !== limit_reg)
                    report_mismatch($sformatf("body_limit read 0x%08h, predicted 0x%08h",
                                              prdata, limit_reg));
            end
            awaited = pending_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the chunked body decoder testbench: clock, reset, byte and register stimulus,
// a randomly stalling result sink and the verdict. Depends on chd_pkg, the decoder RTL
// and chd_decode_checker, which predicts and compares every result.

module tb_top;
    import chd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 95;
    localparam int LONG_HOLD     = 150;
    localparam int HOLD_SPACING  = 300;
    localparam int DRAIN_CYCLES  = 6;
    localparam int NUM_PHASES    = 6;

    localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_BODY_LIMIT, 2'b00};

    // In directed text, these stand for CR and LF.
    localparam logic [BYTE_W-1:0] MARK_CR = 8'h7E;   // '~'
    localparam logic [BYTE_W-1:0] MARK_LF = 8'h7C;   // '|'

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;   // [7:0] data_byte
    logic               s_tlast  = 1'b0; // end_of_input
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [39:0]        m_tdata;         // [7:0] out_byte, [39:8] body_length
    logic [1:0]         m_tuser;         // [1:0] kind
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [DATA_W-1:0]  pwdata   = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int mismatch_count;
    int awaited;

    // Idle bookkeeping: calm counters give stretches with no gaps at all.
    int tx_calm       = 0;
    int rx_calm       = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int results_taken = 0;
    int next_hold_at  = 60;
    int cycle_count   = 0;

    // Bytes of the body being built, sent in order with tlast on the final one.
    logic [BYTE_W-1:0] body_bytes[$];

    http_chunked_body_decoder_top #(
        .SIZE_LINE_MAX (SIZE_LINE_MAX_DEF)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    chd_decode_checker #(
        .SIZE_LINE_MAX (SIZE_LINE_MAX_DEF)
    ) u_decode_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .awaited        (awaited)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs a handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Pick an idle length: mostly none or short, now and then long, and once in a
    // while start a calm stretch in which no idling happens.
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left = $urandom_range(40, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result sink: random stalls, plus a long hold-off every HOLD_SPACING results so
    // that the two-deep pipeline fills and the block pushes back on the byte side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                results_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (results_taken >= next_hold_at)
            begin
                hold_left = LONG_HOLD - 1;
                next_hold_at += HOLD_SPACING;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap(rx_calm);
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Offer one byte after a random gap and hold it until the transfer happens.
    // tready is looked at on the falling edge, where it is settled.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    // Send directed text, with the CR and LF marks swapped for the real characters.
    task automatic send_text(input string txt, input logic last_at_end);
        int                i;
        logic [BYTE_W-1:0] ch;
        for (i = 0; i < txt.len(); i++)
        begin
            ch = txt[i];
            if (ch == MARK_CR) ch = CHAR_CR;
            else if (ch == MARK_LF) ch = CHAR_LF;
            send_byte(ch, last_at_end && (i == txt.len() - 1));
        end
    endtask

    // One APB access to the limit register; a read is checked by the checker.
    // The bus is left idle afterwards so that back-to-back accesses stay apart.
    task automatic access_limit(input logic is_write, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= LIMIT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drop tvalid, wait for every result to come back, then let the pipeline settle.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // Payload content leans toward framing characters to tempt a confused decoder.
    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return CHAR_CR;
            1:       return CHAR_LF;
            2:       return hex_char(4'($urandom_range(0, 15)));
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Append a size line: optional leading CRs, hex digits in mixed case with an
    // occasional leading zero, then LF, CR LF, or CR followed by ignored text.
    task automatic add_size_line(input logic [31:0] chunk_len);
        int          lead;
        int          ndig;
        int          i;
        logic [31:0] tmp;
        lead = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        repeat (lead) body_bytes.push_back(CHAR_CR);
        ndig = 1;
        tmp  = chunk_len;
        while (tmp > 15)
        begin
            tmp = tmp >> 4;
            ndig++;
        end
        if ($urandom_range(0, 4) == 0) ndig++;
        for (i = ndig - 1; i >= 0; i--)
        begin
            tmp = chunk_len >> (4 * i);
            body_bytes.push_back(hex_char(tmp[3:0]));
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                body_bytes.push_back(CHAR_LF);
            5, 6, 7:
            begin
                body_bytes.push_back(CHAR_CR);
                body_bytes.push_back(CHAR_LF);
            end
            default:
            begin
                body_bytes.push_back(CHAR_CR);
                body_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 1) != 0) body_bytes.push_back(CHAR_CR);
                body_bytes.push_back(CHAR_LF);
            end
        endcase
    endtask

    // Build and send one body. Most are well formed with random content; a huge
    // chunk is always cut short by the end of the stream; a quarter of the rest
    // get truncated, corrupted, padded, thinned or replaced by noise.
    task automatic send_random_body(inout int sent);
        int nchunks;
        int c;
        int n;
        int chunk_len;
        int idx;
        bit cut;
        body_bytes.delete();
        cut     = 1'b0;
        nchunks = $urandom_range(0, 3);
        for (c = 0; c < nchunks && !cut; c++)
        begin
            case ($urandom_range(0, 19))
                18:
                begin
                    chunk_len = $urandom_range(24'h10_0000, 24'hFF_FFFF);
                    cut = 1'b1;
                end
                19:      chunk_len = $urandom_range(41, 120);
                default: chunk_len = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(9, 40) : $urandom_range(1, 8);
            endcase
            add_size_line(chunk_len);
            n = cut ? $urandom_range(1, 4) : chunk_len;
            repeat (n) body_bytes.push_back(payload_byte());
            if (!cut)
            begin
                body_bytes.push_back(CHAR_CR);
                body_bytes.push_back(CHAR_LF);
            end
        end
        if (!cut)
        begin
            // closing line: bare LF, CR LF with no digit, or a zero size
            case ($urandom_range(0, 5))
                0: body_bytes.push_back(CHAR_LF);
                1:
                begin
                    body_bytes.push_back(CHAR_CR);
                    body_bytes.push_back(CHAR_LF);
                end
                default: add_size_line(0);
            endcase
            // stray bytes after the finish
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) body_bytes.push_back(payload_byte());
            if ($urandom_range(0, 3) == 0)
            begin
                idx = $urandom_range(0, body_bytes.size() - 1);
                case ($urandom_range(0, 4))
                    0: while (body_bytes.size() > idx + 1) void'(body_bytes.pop_back());
                    1: body_bytes[idx] = BYTE_W'($urandom_range(0, 255));
                    2: body_bytes.insert(idx, payload_byte());
                    3: if (body_bytes.size() > 1) body_bytes.delete(idx);
                    default:
                    begin
                        body_bytes.delete();
                        repeat ($urandom_range(1, 8)) body_bytes.push_back(payload_byte());
                    end
                endcase
            end
        end
        for (idx = 0; idx < body_bytes.size(); idx++)
            send_byte(body_bytes[idx], idx == body_bytes.size() - 1);
        sent += body_bytes.size();
    endtask

    initial
    begin
        logic [DATA_W-1:0] limit_plan[NUM_PHASES];
        int                p;
        int                sent;

        // limits: none allowed, a few bytes, small random, mid, wide random, all ones
        limit_plan[0] = '0;
        limit_plan[1] = 32'd3;
        limit_plan[2] = $urandom_range(1, 40);
        limit_plan[3] = 32'h8000_0000;
        limit_plan[4] = $urandom;
        limit_plan[5] = '1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        access_limit(1'b1, '1);
        access_limit(1'b0, '0);

        // Directed bodies ('~' is CR, '|' is LF).
        // Leading CR, closing CR with an ignored digit, an 0xFF payload, trailer,
        // zero size line, then a 0x00 ignored after the finish that ends the stream.
        send_text("~1~a|", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("~|0|", 1'b0);
        send_byte(8'h00, 1'b1);
        // a non-hex character in the size line
        send_text("g", 1'b1);
        // bad byte where the trailer CR belongs
        send_text("2|pqX", 1'b1);
        // size line one character too long
        send_text("1234567|", 1'b1);
        // stream ends on a payload byte
        send_text("1|z", 1'b1);

        // Random phases, each under its own limit.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            access_limit(1'b1, limit_plan[p]);
            access_limit(1'b0, '0);
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_random_body(sent);
        end

        settle();
        if (mismatch_count == 0 && awaited == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- http_chunked_body_decoder_top.f -----
+incdir+rtl
rtl/chd_pkg.sv
rtl/chd_cfg.sv
rtl/chd_core.sv
rtl/http_chunked_body_decoder_top.sv
tb/sv/chd_decode_checker.sv
tb/sv/tb_top.sv
